// ===== rtl/max_segment_tree_macros.svh =====
// ----------------------------------------------------------------------------
// max segment tree assertion macros
// shared check forms for the range-maximum tree rtl
// ----------------------------------------------------------------------------
`ifndef MAX_SEGMENT_TREE_MACROS_SVH
`define MAX_SEGMENT_TREE_MACROS_SVH

// same-cycle implication, held off during reset
`define MST_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mst: same-cycle check failed");

// next-cycle implication, held off during reset
`define MST_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mst: next-cycle check failed");

`endif

// ===== rtl/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// mst_pkg
// widths, command codes and shared types of the range-maximum tree
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mst_pkg;

   localparam int IDX_W  = 11;
   localparam int DATA_W = 32;

   // leaves_in_use after reset
   localparam logic [IDX_W-1:0] CSR_RESET = 11'd1024;

   localparam logic CMD_RAISE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] range_max;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/mst_channels.sv =====
// ----------------------------------------------------------------------------
// mst channels
// valid/ready channel bundles for request, response and csr write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mst_req_if
   import mst_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic        [IDX_W-1:0]  leaf_index;
   logic signed [DATA_W-1:0] new_value;
   logic        [IDX_W-1:0]  range_low;
   logic        [IDX_W-1:0]  range_high;

   modport source (output valid, cmd, leaf_index, new_value, range_low, range_high,
                   input ready);
   modport sink   (input valid, cmd, leaf_index, new_value, range_low, range_high,
                   output ready);
endinterface

interface mst_rsp_if
   import mst_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] range_max;

   modport source (output valid, range_max, input ready);
   modport sink   (input valid, range_max, output ready);
endinterface

interface mst_csr_if
   import mst_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] leaves_in_use;

   modport source (output valid, leaves_in_use, input ready);
   modport sink   (input valid, leaves_in_use, output ready);
endinterface

`default_nettype wire

// ===== rtl/max_segment_tree.sv =====
// a raise holds the request port through one read-modify-write per tree level,
//   from the leaf up to the root
// a query walks the tree after acceptance, paced by the dual-read tree memory,
//   one level per cycle
// one request in flight; the next is taken while a response waits
// after reset a clearing pass zeroes all 2*LEAVES tree entries before requests
// ----------------------------------------------------------------------------
// max_segment_tree
// range-maximum segment tree with point raise updates over a tree memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module max_segment_tree
   import mst_pkg::*;
#(
   parameter int LEAVES = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   mst_req_if.sink   req_ch,
   mst_rsp_if.source rsp_ch,
   mst_csr_if.sink   csr_ch
);

   localparam int DEPTH = 2 * LEAVES;
   localparam int AW    = $clog2(DEPTH);

   logic [IDX_W-1:0]         leaves_in_use_ff, leaves_in_use_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_range_max_ff, rsp_range_max_in;

   result_type               res;
   logic                     res_ready;

   logic                     ram_wr_en;
   logic [AW-1:0]            ram_wr_addr, ram_rd_addr_a, ram_rd_addr_b;
   logic [DATA_W-1:0]        ram_wr_data, ram_rd_data_a, ram_rd_data_b;

   assign csr_ch.ready = 1'b1;
   assign leaves_in_use_in = csr_ch.valid ? csr_ch.leaves_in_use : leaves_in_use_ff;

   // response register frees the sequencer while a result waits
   assign res_ready        = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_valid_in     = (res.valid && res_ready) || (rsp_valid_ff && !rsp_ch.ready);
   assign rsp_range_max_in = (res.valid && res_ready) ? res.range_max : rsp_range_max_ff;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.range_max = rsp_range_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         leaves_in_use_ff <= CSR_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         leaves_in_use_ff <= leaves_in_use_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_range_max_ff <= rsp_range_max_in;
   end

   mst_tree_ctrl #(
      .LEAVES (LEAVES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .leaves_in_use (leaves_in_use_ff),
      .res           (res),
      .res_ready     (res_ready),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_addr_a (ram_rd_addr_a),
      .ram_rd_addr_b (ram_rd_addr_b),
      .ram_rd_data_a (ram_rd_data_a),
      .ram_rd_data_b (ram_rd_data_b)
   );

   mst_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_tree_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (ram_rd_data_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (ram_rd_data_b)
   );

endmodule

`default_nettype wire

// ===== rtl/mst_ram.sv =====
// ----------------------------------------------------------------------------
// mst_ram
// generic one-write two-read synchronous ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

// ===== rtl/mst_tree_ctrl.sv =====
// ----------------------------------------------------------------------------
// mst_tree_ctrl
// sequencer for tree clear, leaf raise with ancestor rewrite, and range query
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "max_segment_tree_macros.svh"

module mst_tree_ctrl
   import mst_pkg::*;
#(
   parameter int LEAVES = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   mst_req_if.sink                                req_ch,
   input  wire logic [IDX_W-1:0]                  leaves_in_use,
   output      result_type                        res,
   input  wire logic                              res_ready,
   output      logic                              ram_wr_en,
   output      logic [$clog2(2*LEAVES)-1:0]       ram_wr_addr,
   output      logic [DATA_W-1:0]                 ram_wr_data,
   output      logic [$clog2(2*LEAVES)-1:0]       ram_rd_addr_a,
   output      logic [$clog2(2*LEAVES)-1:0]       ram_rd_addr_b,
   input  wire logic [DATA_W-1:0]                 ram_rd_data_a,
   input  wire logic [DATA_W-1:0]                 ram_rd_data_b
);

   localparam int DEPTH = 2 * LEAVES;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);
   localparam int CW    = (NW > IDX_W) ? NW : IDX_W;

   localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);
   localparam logic [CW-1:0] ONE_C    = CW'(1);
   localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
   localparam logic [AW-1:0] ROOT     = AW'(1);

   typedef enum logic [5:0] {
      ST_CLEAR    = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_UPD_LEAF = 6'b000100,
      ST_UPD_UP   = 6'b001000,
      ST_QRY      = 6'b010000,
      ST_QRY_DONE = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic        [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic        [NW-1:0]     node_ff, node_in;   // update: current child, query: left bound
   logic        [NW-1:0]     r_ff, r_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] best_ff, best_in;
   logic                     pend_a_ff, pend_a_in;
   logic                     pend_b_ff, pend_b_in;

   // request decode, clipped against the active leaf count
   logic [CW-1:0] csr_cw, n_cw, idx_cw, leaf_cw;
   logic [CW-1:0] lo_cw, hi_cw, l0_cw, r0_cw;
   logic          upd_ok, q_ok;

   assign csr_cw  = CW'(leaves_in_use);
   assign n_cw    = (csr_cw > LEAVES_C) ? LEAVES_C : csr_cw;
   assign idx_cw  = CW'(req_ch.leaf_index);
   assign upd_ok  = (idx_cw != '0) && (idx_cw <= n_cw);
   assign leaf_cw = LEAVES_C + idx_cw - ONE_C;
   assign lo_cw   = (req_ch.range_low == '0) ? ONE_C : CW'(req_ch.range_low);
   assign hi_cw   = (CW'(req_ch.range_high) > n_cw) ? n_cw : CW'(req_ch.range_high);
   assign q_ok    = (lo_cw <= hi_cw);
   assign l0_cw   = LEAVES_C + lo_cw - ONE_C;
   assign r0_cw   = LEAVES_C + hi_cw;

   // datapath shared by the steps
   logic signed [DATA_W-1:0] rd_a_s, rd_b_s, mx, acc_a, acc_b;
   logic        [AW-1:0]     parent;
   logic        [NW-1:0]     l_next, r_next, r_m1;
   logic                     q_more;

   assign rd_a_s = $signed(ram_rd_data_a);
   assign rd_b_s = $signed(ram_rd_data_b);
   assign mx     = (rd_a_s > val_ff) ? rd_a_s : val_ff;
   assign parent = node_ff[AW-1:0] >> 1;
   assign acc_a  = (pend_a_ff && (rd_a_s > best_ff)) ? rd_a_s : best_ff;
   assign acc_b  = (pend_b_ff && (rd_b_s > acc_a)) ? rd_b_s : acc_a;
   assign q_more = (node_ff < r_ff);
   assign l_next = (node_ff + NW'(node_ff[0])) >> 1;
   assign r_next = (r_ff - NW'(r_ff[0])) >> 1;
   assign r_m1   = r_ff - NW'(1);

   assign req_ch.ready  = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      node_in       = node_ff;
      r_in          = r_ff;
      val_in        = val_ff;
      best_in       = best_ff;
      pend_a_in     = 1'b0;
      pend_b_in     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = node_ff[AW-1:0];
      ram_wr_data   = mx;
      ram_rd_addr_a = node_ff[AW-1:0];
      ram_rd_addr_b = r_m1[AW-1:0];
      res.valid     = 1'b0;
      res.range_max = best_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.cmd == CMD_QUERY) begin
                  best_in  = '0;
                  node_in  = l0_cw[NW-1:0];
                  r_in     = r0_cw[NW-1:0];
                  state_in = q_ok ? ST_QRY : ST_QRY_DONE;
               end else if (upd_ok) begin
                  node_in       = leaf_cw[NW-1:0];
                  val_in        = req_ch.new_value;
                  ram_rd_addr_a = leaf_cw[AW-1:0];
                  state_in      = ST_UPD_LEAF;
               end
            end
         end
         ST_UPD_LEAF: begin
            // leaf data is back: merge, write, fetch the sibling
            ram_wr_en     = 1'b1;
            ram_wr_addr   = node_ff[AW-1:0];
            val_in        = mx;
            ram_rd_addr_a = node_ff[AW-1:0] ^ ROOT;
            state_in      = ST_UPD_UP;
         end
         ST_UPD_UP: begin
            // sibling data is back: parent = max of both children
            ram_wr_en   = 1'b1;
            ram_wr_addr = parent;
            val_in      = mx;
            if (parent == ROOT) begin
               state_in = ST_IDLE;
            end else begin
               node_in       = NW'(parent);
               ram_rd_addr_a = parent ^ ROOT;
            end
         end
         ST_QRY: begin
            best_in = acc_b;
            if (q_more) begin
               ram_rd_addr_a = node_ff[AW-1:0];
               ram_rd_addr_b = r_m1[AW-1:0];
               pend_a_in     = node_ff[0];
               pend_b_in     = r_ff[0];
               node_in       = l_next;
               r_in          = r_next;
            end else begin
               state_in = ST_QRY_DONE;
            end
         end
         ST_QRY_DONE: begin
            res.valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         pend_a_ff  <= 1'b0;
         pend_b_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         pend_a_ff  <= pend_a_in;
         pend_b_ff  <= pend_b_in;
      end
      node_ff <= node_in;
      r_ff    <= r_in;
      val_ff  <= val_in;
      best_ff <= best_in;
   end

   `MST_ASSERT_IMP(a_query_no_write, clock, reset,
      (state_ff == ST_QRY) || (state_ff == ST_QRY_DONE), !ram_wr_en)
   `MST_ASSERT_IMP(a_clear_full_sweep, clock, reset,
      $past(state_ff == ST_CLEAR) && (state_ff == ST_IDLE), $past(clr_cnt_ff) == CLR_LAST)
   `MST_ASSERT_IMP(a_result_drained, clock, reset, res.valid, !pend_a_ff && !pend_b_ff)
   `MST_ASSERT_NEXT(a_update_climbs, clock, reset,
      (state_ff == ST_UPD_UP) && (parent != ROOT), node_ff == ($past(node_ff) >> 1))

endmodule

`default_nettype wire
